### hw/rtl/adfp_pkg.sv
// ----------------------------------------------------------------------------
// adfp_pkg
// Shared constants, types and tables for the ASCII decimal to fixed-point core.
// ----------------------------------------------------------------------------
package adfp_pkg;

    localparam int VALUE_BITS = 16;
    localparam int MAG_W      = VALUE_BITS - 1;
    localparam int GROW_W     = MAG_W + 4;
    localparam int TDATA_W    = ((VALUE_BITS + 8 + 7) / 8) * 8;
    localparam int TUSER_W    = 4;

    localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NODIGITS = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] END_TERM  = 2'd0;
    localparam logic [1:0] END_LIMIT = 2'd1;
    localparam logic [1:0] END_BUF   = 2'd2;

    localparam logic [2:0] FD_RESET = 3'd2;

    // Largest magnitude that survives n further scalings by ten
    localparam logic [63:0] LIM_0 = 64'(MAX_MAG);
    localparam logic [63:0] LIM_1 = LIM_0 / 10;
    localparam logic [63:0] LIM_2 = LIM_0 / 100;
    localparam logic [63:0] LIM_3 = LIM_0 / 1000;
    localparam logic [63:0] LIM_4 = LIM_0 / 10000;
    localparam logic [63:0] LIM_5 = LIM_0 / 100000;
    localparam logic [63:0] LIM_6 = LIM_0 / 1000000;
    localparam logic [63:0] LIM_7 = LIM_0 / 10000000;

    localparam logic [63:0] P10_0 = 64'd1;
    localparam logic [63:0] P10_1 = 64'd10;
    localparam logic [63:0] P10_2 = 64'd100;
    localparam logic [63:0] P10_3 = 64'd1000;
    localparam logic [63:0] P10_4 = 64'd10000;
    localparam logic [63:0] P10_5 = 64'd100000;
    localparam logic [63:0] P10_6 = 64'd1000000;
    localparam logic [63:0] P10_7 = 64'd10000000;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             dseen;
        logic             ovf;
        logic [2:0]       scale_n;
        logic [1:0]       how;
        logic [7:0]       term;
    } t_close;

    function automatic logic [MAG_W-1:0] sat_limit(input logic [2:0] n);
        logic [63:0] l;
        unique case (n)
            3'd0: l = LIM_0;
            3'd1: l = LIM_1;
            3'd2: l = LIM_2;
            3'd3: l = LIM_3;
            3'd4: l = LIM_4;
            3'd5: l = LIM_5;
            3'd6: l = LIM_6;
            3'd7: l = LIM_7;
            default: l = LIM_0;
        endcase
        return l[MAG_W-1:0];
    endfunction

    // Low bits of 10^n; enough since unsaturated products fit in MAG_W bits
    function automatic logic [MAG_W-1:0] pow10_low(input logic [2:0] n);
        logic [63:0] p;
        unique case (n)
            3'd0: p = P10_0;
            3'd1: p = P10_1;
            3'd2: p = P10_2;
            3'd3: p = P10_3;
            3'd4: p = P10_4;
            3'd5: p = P10_5;
            3'd6: p = P10_6;
            3'd7: p = P10_7;
            default: p = P10_0;
        endcase
        return p[MAG_W-1:0];
    endfunction

endpackage

### hw/rtl/adfp_parse.sv
// ----------------------------------------------------------------------------
// adfp_parse
// Per-character field state: sign, digits, point, fraction count, closing.
// ----------------------------------------------------------------------------
module adfp_parse import adfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_fd,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic       i_take,
    output logic       o_adv,
    output logic       o_cl_valid,
    output t_close     o_cl
);

    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [1:0]       r_phase, n_phase;
    logic [2:0]       r_dec, n_dec;
    logic             r_dseen, n_dseen;
    logic             r_ovf, n_ovf;
    logic             r_cl_valid, n_cl_valid;
    t_close           r_cl, n_cl;

    logic              first;
    logic [1:0]        ph;
    logic              is_digit;
    logic [GROW_W-1:0] mag_w;
    logic [GROW_W-1:0] grown;
    logic              close_now;
    logic [1:0]        how;
    logic [7:0]        term;

    assign o_adv = i_valid && (!r_cl_valid || i_take);

    always_comb begin
        first    = (r_phase == PH_FIRST);
        ph       = first ? PH_INT : r_phase;
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        mag_w    = GROW_W'(r_mag);
        grown    = (mag_w << 3) + (mag_w << 1) + GROW_W'(i_char[3:0]);

        n_mag     = r_mag;
        n_neg     = r_neg;
        n_phase   = ph;
        n_dec     = r_dec;
        n_dseen   = r_dseen;
        n_ovf     = r_ovf;
        close_now = 1'b0;
        how       = END_BUF;
        term      = 8'd0;

        if (first && i_char == CH_MINUS) begin
            n_neg     = 1'b1;
            close_now = i_last;
        end else if (is_digit) begin
            n_dseen = 1'b1;
            if (grown > GROW_W'(MAX_MAG)) begin
                n_mag = MAX_MAG;
                n_ovf = 1'b1;
            end else begin
                n_mag = grown[MAG_W-1:0];
            end
            if (ph == PH_FRAC) begin
                n_dec = r_dec + 3'd1;
            end
            if (ph == PH_FRAC && n_dec == i_fd) begin
                close_now = 1'b1;
                how       = END_LIMIT;
            end else begin
                close_now = i_last;
            end
        end else if (i_char == CH_POINT && ph != PH_FRAC && i_fd != 3'd0) begin
            n_phase   = PH_FRAC;
            close_now = i_last;
        end else begin
            close_now = 1'b1;
            how       = END_TERM;
            term      = i_char;
        end

        n_cl.mag     = n_mag;
        n_cl.neg     = n_neg;
        n_cl.dseen   = n_dseen;
        n_cl.ovf     = n_ovf;
        n_cl.scale_n = (i_fd > n_dec) ? (i_fd - n_dec) : 3'd0;
        n_cl.how     = how;
        n_cl.term    = term;

        n_cl_valid = r_cl_valid && !i_take;
        if (o_adv) begin
            n_cl_valid = close_now;
        end

        if (!o_adv) begin
            n_mag   = r_mag;
            n_neg   = r_neg;
            n_phase = r_phase;
            n_dec   = r_dec;
            n_dseen = r_dseen;
            n_ovf   = r_ovf;
        end else if (close_now) begin
            n_mag   = '0;
            n_neg   = 1'b0;
            n_phase = PH_FIRST;
            n_dec   = 3'd0;
            n_dseen = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_phase    <= PH_FIRST;
            r_dec      <= 3'd0;
            r_dseen    <= 1'b0;
            r_ovf      <= 1'b0;
            r_cl_valid <= 1'b0;
        end else begin
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_phase    <= n_phase;
            r_dec      <= n_dec;
            r_dseen    <= n_dseen;
            r_ovf      <= n_ovf;
            r_cl_valid <= n_cl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_cl <= n_cl;
        end
    end

    assign o_cl_valid = r_cl_valid;
    assign o_cl       = r_cl;

endmodule

### hw/rtl/adfp_scale.sv
// ----------------------------------------------------------------------------
// adfp_scale
// Applies missing fraction scaling with saturation and drives the result register.
// ----------------------------------------------------------------------------
module adfp_scale import adfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cl_valid,
    input  t_close                i_cl,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [1:0]            o_status,
    output logic [1:0]            o_ended_by,
    output logic [7:0]            o_term
);

    logic                  r_valid, n_valid;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [1:0]            r_status, n_status;
    logic [1:0]            r_ended_by;
    logic [7:0]            r_term;

    logic [2*MAG_W-1:0]    prod;
    logic                  sat;
    logic [MAG_W-1:0]      scaled;
    logic [VALUE_BITS-1:0] mag_ext;

    assign o_take = i_cl_valid && (!r_valid || i_ready);

    always_comb begin
        prod    = (2*MAG_W)'(i_cl.mag) * (2*MAG_W)'(pow10_low(i_cl.scale_n));
        sat     = i_cl.mag > sat_limit(i_cl.scale_n);
        scaled  = sat ? MAX_MAG : prod[MAG_W-1:0];
        mag_ext = VALUE_BITS'(scaled);
        if (!i_cl.dseen) begin
            n_value  = '0;
            n_status = ST_NODIGITS;
        end else begin
            n_value  = i_cl.neg ? (-mag_ext) : mag_ext;
            n_status = (i_cl.ovf || sat) ? ST_OVERFLOW : ST_OK;
        end
        n_valid = o_take || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_value    <= n_value;
            r_status   <= n_status;
            r_ended_by <= i_cl.how;
            r_term     <= i_cl.term;
        end
    end

    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_status   = r_status;
    assign o_ended_by = r_ended_by;
    assign o_term     = r_term;

endmodule

### hw/rtl/ascii_decimal_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point_core
// Streams ASCII characters in, emits one signed fixed-point result per field.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while results are taken, limited by the field state update loop.
// Path: a closing character passes the input register, close register and result
//   register in that order before its result is valid.
// Reset: synchronous active low; clears field state, empties all stages and
//   sets fraction digits to 2. No clearing pass.
module ascii_decimal_to_fixed_point_core import adfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] character
    input  logic               s_axis_tlast,   // ends_buffer
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // value, terminator
    output logic [TUSER_W-1:0] m_axis_tuser,   // [1:0] status, [3:2] ended_by
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [2:0] r_fd;

    logic                  adv;
    logic                  take;
    logic                  cl_valid;
    t_close                cl;
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            status;
    logic [1:0]            ended_by;
    logic [7:0]            term;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_in_valid || adv;

    always_comb begin
        n_in_valid = r_in_valid && !adv;
        if (s_axis_tvalid && s_axis_tready) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fd       <= FD_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    adfp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fd       (r_fd),
        .i_valid    (r_in_valid),
        .i_char     (r_char),
        .i_last     (r_last),
        .i_take     (take),
        .o_adv      (adv),
        .o_cl_valid (cl_valid),
        .o_cl       (cl)
    );

    adfp_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cl_valid (cl_valid),
        .i_cl       (cl),
        .o_take     (take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (value),
        .o_status   (status),
        .o_ended_by (ended_by),
        .o_term     (term)
    );

    assign m_axis_tdata = TDATA_W'({term, value});
    assign m_axis_tuser = {ended_by, status};

endmodule

### hw/rtl/adfp_checker.sv
// ----------------------------------------------------------------------------
// adfp_props
// Port-level checks on results of the ASCII decimal to fixed-point core.
// ----------------------------------------------------------------------------
module adfp_props import adfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic [TUSER_W-1:0] m_axis_tuser
);

    logic [VALUE_BITS-1:0] value;
    logic [7:0]            term;

    assign value = m_axis_tdata[VALUE_BITS-1:0];
    assign term  = m_axis_tdata[VALUE_BITS+7:VALUE_BITS];

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_nodigit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == ST_NODIGITS |-> value == '0)
        else $error("no-digit result with nonzero value");

    a_term_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:2] == END_LIMIT || m_axis_tuser[3:2] == END_BUF)
            |-> term == 8'd0)
        else $error("terminator set on non-terminator close");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3 && m_axis_tuser[3:2] != 2'd3
            && value != {1'b1, {(VALUE_BITS-1){1'b0}}})
        else $error("invalid result code or value");

endmodule

bind ascii_decimal_to_fixed_point_core adfp_props u_adfp_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/adfp_checker.sv
// ----------------------------------------------------------------------------
// adfp_checker
// Watches the character, result and fraction-digit channels of the ASCII
// decimal to fixed-point core, predicts every result from the accepted
// characters and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module adfp_checker import adfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] character
    input  logic               s_axis_tlast,   // ends_buffer
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,   // [15:0] value, [23:16] terminator
    input  logic [TUSER_W-1:0] m_axis_tuser,   // [1:0] status, [3:2] ended_by
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [1:0]            status;
        logic [1:0]            ended_by;
        logic [7:0]            term;
    } t_fixed_result;

    logic [2:0]       frac_digits;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [1:0]       phase;
    logic [2:0]       dec_cnt;
    logic             dseen;
    logic             ovf;

    t_fixed_result    expected_results[$];

    function void clear_field();
        mag     = '0;
        neg     = 1'b0;
        phase   = PH_FIRST;
        dec_cnt = '0;
        dseen   = 1'b0;
        ovf     = 1'b0;
    endfunction

    // Magnitude times ten plus digit, clamped at the largest magnitude
    function void grow(input logic [3:0] d);
        logic [63:0] nxt;
        nxt = 64'(mag) * 64'd10 + 64'(d);
        if (nxt > 64'(MAX_MAG)) begin
            nxt = 64'(MAX_MAG);
            ovf = 1'b1;
        end
        mag = nxt[MAG_W-1:0];
    endfunction

    function void close_field(input logic [1:0] how, input logic [7:0] term);
        t_fixed_result r;
        for (int k = int'(dec_cnt); k < int'(frac_digits); k++)
            grow(4'd0);
        if (!dseen) begin
            r.value  = '0;
            r.status = ST_NODIGITS;
        end else begin
            r.value = {1'b0, mag};
            if (neg)
                r.value = -r.value;
            r.status = ovf ? ST_OVERFLOW : ST_OK;
        end
        r.ended_by = how;
        r.term     = term;
        expected_results.push_back(r);
        clear_field();
    endfunction

    function void take_char(input logic [7:0] c, input logic last);
        if (phase == PH_FIRST) begin
            phase = PH_INT;
            if (c == CH_MINUS) begin
                neg = 1'b1;
                if (last)
                    close_field(END_BUF, 8'h00);
                return;
            end
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            dseen = 1'b1;
            grow(4'(c - CH_ZERO));
            if (phase == PH_FRAC) begin
                dec_cnt = dec_cnt + 3'd1;
                if (dec_cnt == frac_digits) begin
                    close_field(END_LIMIT, 8'h00);
                    return;
                end
            end
        end else if (c == CH_POINT && phase != PH_FRAC && frac_digits != 3'd0) begin
            phase = PH_FRAC;
        end else begin
            close_field(END_TERM, c);
            return;
        end
        if (last)
            close_field(END_BUF, 8'h00);
    endfunction

    function void note_mismatch(input string what, input t_fixed_result want,
                                input t_fixed_result got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display({"ERROR: %s: expected value %0d status %0d ended_by %0d term 0x%02h,",
                      " got value %0d status %0d ended_by %0d term 0x%02h"},
                     what, $signed(want.value), want.status, want.ended_by, want.term,
                     $signed(got.value), got.status, got.ended_by, got.term);
    endfunction

    always @(posedge i_clk) begin
        t_fixed_result got;
        t_fixed_result want;
        if (!i_rst_n) begin
            frac_digits = FD_RESET;
            clear_field();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                frac_digits = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                take_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.value    = m_axis_tdata[VALUE_BITS-1:0];
                got.term     = m_axis_tdata[VALUE_BITS +: 8];
                got.status   = m_axis_tuser[1:0];
                got.ended_by = m_axis_tuser[3:2];
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives ASCII characters and fraction-digit settings into the decimal to
// fixed-point core: a directed set of corner fields, then random fields and
// noise under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb import adfp_pkg::*;;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] character
    logic               s_axis_tlast;   // ends_buffer
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // [15:0] value, [23:16] terminator
    logic [TUSER_W-1:0] m_axis_tuser;   // [1:0] status, [3:2] ended_by
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_req;
    int n_sent;
    int cur_fd;

    ascii_decimal_to_fixed_point_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    adfp_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        n_sent++;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function automatic logic rand_last();
        return $urandom_range(15) == 0;
    endfunction

    // Optional sign, integer digits, optional point and fraction digits, optional terminator
    task automatic send_number();
        int n_int;
        int n_frac;
        logic [7:0] t;
        n_int = ($urandom_range(7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        if ($urandom_range(1))
            send_char(CH_MINUS, rand_last());
        repeat (n_int)
            send_char(8'(CH_ZERO + $urandom_range(9)), rand_last());
        if ($urandom_range(9) < 6) begin
            send_char(CH_POINT, rand_last());
            n_frac = $urandom_range(0, cur_fd + 1);
            repeat (n_frac)
                send_char(8'(CH_ZERO + $urandom_range(9)), rand_last());
        end
        if ($urandom_range(2) != 0) begin
            case ($urandom_range(4))
                0: t = ",";
                1: t = " ";
                2: t = 8'h0D;
                3: t = 8'h0A;
                default: t = 8'($urandom_range(255));
            endcase
            send_char(t, rand_last());
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_frac_digits(input logic [2:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_fd = v;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int items, input int tx, input int rx,
                             input int hold, input bit mid_pause);
        int start;
        bit paused;
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        start        = n_sent;
        paused       = 1'b0;
        if (hold != 0)
            rx_hold_req = hold;
        while (n_sent - start < items) begin
            if (mid_pause && !paused && n_sent - start >= items / 2) begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(99) < 85)
                send_number();
            else
                send_noise();
        end
        // space always closes an open field
        send_char(" ", 1'b0);
        drain();
    endtask

    initial begin
        int fd_plan[9];
        fd_plan       = '{2, 0, 4, 7, 1, 3, 5, 6, 2};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold_req   = 0;
        n_sent        = 0;
        cur_fd        = FD_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner fields at the reset setting of two fraction digits
        send_text("-9.99", 1'b0);           // closes on digit limit
        send_text("0,", 1'b0);
        send_text("-", 1'b1);               // lone minus at end of buffer
        send_char(CH_POINT, 1'b0);          // lone point, NUL terminator
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);             // terminator as first byte
        send_text("400", 1'b1);             // saturates while scaling
        send_text("-5", 1'b1);
        send_text("1.", 1'b1);
        send_text("7;", 1'b1);              // terminator on last byte
        send_text("1.2.", 1'b0);            // second point terminates
        drain();

        for (int p = 0; p < 9; p++) begin
            if (p != 0)
                write_frac_digits(3'(fd_plan[p]));
            case (p % 4)
                0: run_phase(100, 0, 0, (p == 0) ? 400 : 0, 1'b0);
                1: run_phase(100, 55, 0, 0, p == 5);
                2: run_phase(100, 0, 55, 0, 1'b0);
                default: run_phase(100, 29, 29, 0, 1'b0);
            endcase
        end

        drain();
        repeat (6) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### ascii_decimal_to_fixed_point_core.f
hw/rtl/adfp_pkg.sv
hw/rtl/adfp_parse.sv
hw/rtl/adfp_scale.sv
hw/rtl/ascii_decimal_to_fixed_point_core.sv
hw/rtl/adfp_checker.sv
bench/adfp_checker.sv
bench/tb.sv
